### src/ogrc_pkg.sv
// Shared types, constants and tables of the occupancy grid ray caster.
// Depends on nothing; every other file but ogrc_ram imports it.
package ogrc_pkg;

    // Map store geometry
    localparam int MAP_SIDE   = 512;
    localparam int MAP_SIDE_W = $clog2(MAP_SIDE);
    localparam int COLS_W     = MAP_SIDE_W + 1;
    localparam int MAP_CELLS  = MAP_SIDE * MAP_SIDE;
    localparam int MAP_ADDR_W = $clog2(MAP_CELLS);

    // Beam numbering
    localparam int MAX_BEAMS = 4096;

    // Datapath widths
    localparam int STEP_W  = 21;               // cell edge
    localparam int DIST_W  = 25;               // distance along the beam
    localparam int TRIG_W  = 33;               // cosine and sine, Q2.30 plus headroom
    localparam int Z_W     = 18;               // CORDIC residual angle
    localparam int PROD_W  = DIST_W + 1 + TRIG_W;
    localparam int F_W     = PROD_W - 30;      // beam offset in Q13.16
    localparam int REM_W   = 30;               // in-cell remainder
    localparam int GRID_W  = 36;               // cell coordinate
    localparam int DIVD_W  = 32;               // magnitude of pose minus origin
    localparam int APB_ADDR_W = 5;

    // CORDIC
    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // Request queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic signed [7:0] WALL_VALUE = 8'sd100;

    // Register indexes
    localparam logic [2:0] REG_CELL_SIZE    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X     = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd2;
    localparam logic [2:0] REG_MAP_COLUMNS  = 3'd3;
    localparam logic [2:0] REG_MAP_ROWS     = 3'd4;
    localparam logic [2:0] REG_MAX_RANGE    = 3'd5;
    localparam logic [2:0] REG_FIRST_ANGLE  = 3'd6;
    localparam logic [2:0] REG_ANGLE_STEP   = 3'd7;

    // Register reset values
    localparam logic [20:0] CELL_SIZE_RST   = 21'd3277;
    localparam logic [9:0]  MAP_SIZE_RST    = 10'd512;
    localparam logic [23:0] MAX_RANGE_RST   = 24'd655360;
    localparam logic [15:0] ANGLE_STEP_RST  = 16'd46;

    typedef struct packed {
        logic               cmd;
        logic [17:0]        cell_index;
        logic signed [7:0]  cell_value;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic [15:0]        robot_heading;
        logic [11:0]        beam_number;
    } request_t;

    typedef struct packed {
        logic [11:0] beam_out;
        logic        hit;
        logic [24:0] hit_range;
    } result_t;

    typedef struct packed {
        logic [20:0]        cell_size;
        logic signed [31:0] map_origin_x;
        logic signed [31:0] map_origin_y;
        logic [9:0]         map_columns;
        logic [9:0]         map_rows;
        logic [23:0]        max_range;
        logic [15:0]        first_beam_angle;
        logic [15:0]        beam_angle_step;
    } cfg_t;

    // Classified request as held in the queue
    typedef struct packed {
        logic                  cmd;
        logic                  cell_keep;
        logic                  cell_wall;
        logic [MAP_ADDR_W-1:0] cell_addr;
        logic [11:0]           beam;
        logic [15:0]           angle;
        logic signed [31:0]    pos_x;
        logic signed [31:0]    pos_y;
    } entry_t;

    // Arctangent of 2^-i in binary angle units
    function automatic logic [13:0] atan_unit(input logic [ITER_W-1:0] i);
        logic [13:0] a;
        case (i)
            4'd0:    a = 14'd8192;
            4'd1:    a = 14'd4836;
            4'd2:    a = 14'd2555;
            4'd3:    a = 14'd1297;
            4'd4:    a = 14'd651;
            4'd5:    a = 14'd326;
            4'd6:    a = 14'd163;
            4'd7:    a = 14'd81;
            4'd8:    a = 14'd41;
            4'd9:    a = 14'd20;
            4'd10:   a = 14'd10;
            4'd11:   a = 14'd5;
            4'd12:   a = 14'd3;
            4'd13:   a = 14'd1;
            4'd14:   a = 14'd1;
            default: a = 14'd0;
        endcase
        return a;
    endfunction

endpackage

### src/ogrc_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module ogrc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### src/ogrc_front.sv
// Front end: takes requests, decodes the command and works out the beam angle.
// Depends on ogrc_pkg.
module ogrc_front (
    input  logic              start,
    input  ogrc_pkg::request_t request,
    input  logic [15:0]       first_beam_angle,
    input  logic [15:0]       beam_angle_step,
    input  logic              full,
    output logic              busy,
    output logic              push,
    output ogrc_pkg::entry_t  entry
);
    import ogrc_pkg::*;

    logic [11:0] beam;
    logic [27:0] spin;

    // Hold requests off while the queue is full
    assign busy = full;
    assign push = start && !full;

    // Reduce the beam number and form the beam angle
    assign beam = 12'(request.beam_number % MAX_BEAMS);
    assign spin = 28'(beam) * 28'(beam_angle_step);

    always_comb
    begin
        entry.cmd       = request.cmd;
        entry.cell_keep = ({1'b0, request.cell_index} < 19'(MAP_CELLS));
        entry.cell_wall = (request.cell_value == WALL_VALUE);
        entry.cell_addr = MAP_ADDR_W'(request.cell_index);
        entry.beam      = beam;
        entry.angle     = 16'(request.robot_heading + first_beam_angle + spin[15:0]);
        entry.pos_x     = request.robot_x;
        entry.pos_y     = request.robot_y;
    end

endmodule

### src/ogrc_queue.sv
// Short request queue between the front end and the ray engine.
// Depends on ogrc_pkg.
module ogrc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ogrc_pkg::entry_t din,
    input  logic             pop,
    output ogrc_pkg::entry_t head,
    output logic             head_valid,
    output logic             full
);
    import ogrc_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_pop;

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign do_pop     = pop && head_valid;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### src/ogrc_cordic.sv
// Iterative CORDIC: cosine and sine of a binary angle, one rotation per cycle.
// Depends on ogrc_pkg.
module ogrc_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [15:0]                        angle,
    output logic                               busy,
    output logic signed [ogrc_pkg::TRIG_W-1:0] cos_val,
    output logic signed [ogrc_pkg::TRIG_W-1:0] sin_val
);
    import ogrc_pkg::*;

    logic                     busy_reg, busy_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic                     flip_reg, flip_next;
    logic signed [TRIG_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic signed [TRIG_W-1:0] cos_reg, cos_next, sin_reg, sin_next;
    logic signed [TRIG_W-1:0] xs, ys, nx, ny;
    logic signed [Z_W-1:0]    za, zt;

    assign busy    = busy_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

    // Fold the angle into the right half-plane and rotate
    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        flip_next = flip_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        za        = $signed({2'b00, angle});
        zt        = $signed({4'b0000, atan_unit(iter_reg)});
        xs        = x_reg >>> iter_reg;
        ys        = y_reg >>> iter_reg;
        if (z_reg >= 0)
        begin
            nx = x_reg - ys;
            ny = y_reg + xs;
        end
        else
        begin
            nx = x_reg + ys;
            ny = y_reg - xs;
        end
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            if (angle >= 16'd16384 && angle < 16'd49152)
            begin
                flip_next = 1'b1;
                z_next    = za - 18'sd32768;
            end
            else
            begin
                flip_next = 1'b0;
                z_next    = (angle < 16'd32768) ? za : za - 18'sd65536;
            end
        end
        else if (busy_reg)
        begin
            x_next    = nx;
            y_next    = ny;
            z_next    = (z_reg >= 0) ? z_reg - zt : z_reg + zt;
            iter_next = ITER_W'(iter_reg + 1'b1);
            if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                cos_next  = flip_reg ? -nx : nx;
                sin_next  = flip_reg ? -ny : ny;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg <= iter_next;
        flip_reg <= flip_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

endmodule

### src/ogrc_div.sv
// Restoring divider, one quotient bit per cycle, for the starting cell of a beam.
// Depends on ogrc_pkg.
module ogrc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ogrc_pkg::DIVD_W-1:0]       dividend,
    input  logic [ogrc_pkg::STEP_W-1:0]       divisor,
    output logic                              done,
    output logic [ogrc_pkg::DIVD_W-1:0]       quotient,
    output logic [ogrc_pkg::STEP_W-1:0]       remainder
);
    import ogrc_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVD_W-1:0] dvd_reg, dvd_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] dsr_reg, dsr_next;
    logic [STEP_W:0]   trial;
    logic              fits;

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

    // Shift in one dividend bit and subtract where it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, dvd_reg[DIVD_W-1]};
        fits      = (trial >= {1'b0, dsr_reg});
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVD_W);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? STEP_W'(trial - {1'b0, dsr_reg}) : STEP_W'(trial);
            dvd_next = {dvd_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

endmodule

### src/ogrc_back.sv
// Ray engine: writes map cells and marches beams cell by cell through the map.
// Depends on ogrc_pkg, ogrc_cordic, ogrc_div and ogrc_ram.
module ogrc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ogrc_pkg::cfg_t    cfg,
    input  ogrc_pkg::entry_t  head,
    input  logic              head_valid,
    output logic              pop,
    output logic              done,
    output ogrc_pkg::result_t result
);
    import ogrc_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIVX  = 9'b000000010,
        S_DIVY  = 9'b000000100,
        S_STEP  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_ADD   = 9'b000100000,
        S_NORM  = 9'b001000000,
        S_ADDR  = 9'b010000000,
        S_CHECK = 9'b100000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [11:0]              beam_reg, beam_next;
    logic                     negx_reg, negx_next;
    logic                     negy_reg, negy_next;
    logic signed [32:0]       diffy_reg, diffy_next;
    logic signed [GRID_W-1:0] gx_reg, gx_next, gy_reg, gy_next;
    logic signed [REM_W-1:0]  remx_reg, remx_next, remy_reg, remy_next;
    logic signed [F_W-1:0]    fx_reg, fx_next, fy_reg, fy_next;
    logic [DIST_W-1:0]        dist_reg, dist_next;
    logic signed [PROD_W-1:0] prodx_reg, prodx_next, prody_reg, prody_next;
    logic                     done_reg, done_next;
    result_t                  result_reg, result_next;

    logic [STEP_W-1:0]        step;
    logic [COLS_W-1:0]        cols, rows;
    logic signed [REM_W-1:0]  step_s;
    logic signed [GRID_W-1:0] cols_s, rows_s;
    logic signed [32:0]       diffx;
    logic signed [F_W-1:0]    fxn, fyn;
    logic signed [GRID_W-1:0] gq;
    logic signed [REM_W-1:0]  gr;
    logic                     gneg;

    logic                     trig_start, trig_busy;
    logic signed [TRIG_W-1:0] cos_val, sin_val;
    logic                     div_start, div_done;
    logic [DIVD_W-1:0]        div_dividend, div_quot;
    logic [STEP_W-1:0]        div_rem;
    logic                     ram_we, ram_wdata, ram_rdata;
    logic [MAP_ADDR_W-1:0]    ram_addr, cast_addr;

    ogrc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (trig_start),
        .angle   (head.angle),
        .busy    (trig_busy),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    ogrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (step),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    ogrc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_CELLS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign done   = done_reg;
    assign result = result_reg;

    // Clamp the cell edge and map size
    assign step   = (cfg.cell_size == '0) ? STEP_W'(1) : cfg.cell_size;
    assign cols   = (int'(cfg.map_columns) > MAP_SIDE) ? COLS_W'(MAP_SIDE)
                                                        : COLS_W'(cfg.map_columns);
    assign rows   = (int'(cfg.map_rows) > MAP_SIDE) ? COLS_W'(MAP_SIDE)
                                                     : COLS_W'(cfg.map_rows);
    assign step_s = $signed(REM_W'(step));
    assign cols_s = $signed(GRID_W'(cols));
    assign rows_s = $signed(GRID_W'(rows));

    // Pose offset from the map corner
    assign diffx = $signed({head.pos_x[31], head.pos_x})
                 - $signed({cfg.map_origin_x[31], cfg.map_origin_x});

    // Beam offset from the pose at the current distance
    assign fxn = F_W'(prodx_reg >>> 30);
    assign fyn = F_W'(prody_reg >>> 30);

    // Cell address of the current point
    assign cast_addr = MAP_ADDR_W'(gy_reg[MAP_SIDE_W-1:0]) * MAP_ADDR_W'(cols)
                     + MAP_ADDR_W'(gx_reg[MAP_SIDE_W-1:0]);

    // Turn the unsigned quotient into floor division of a signed offset
    always_comb
    begin
        gneg = (state_reg == S_DIVX) ? negx_reg : negy_reg;
        gq   = $signed(GRID_W'(div_quot));
        gr   = $signed(REM_W'(div_rem));
        if (gneg)
        begin
            if (div_rem != '0)
            begin
                gq = -gq - 1'b1;
                gr = step_s - gr;
            end
            else
            begin
                gq = -gq;
            end
        end
    end

    // Sequence the write and cast commands
    always_comb
    begin
        state_next   = state_reg;
        beam_next    = beam_reg;
        negx_next    = negx_reg;
        negy_next    = negy_reg;
        diffy_next   = diffy_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        remx_next    = remx_reg;
        remy_next    = remy_reg;
        fx_next      = fx_reg;
        fy_next      = fy_reg;
        dist_next    = dist_reg;
        prodx_next   = prodx_reg;
        prody_next   = prody_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        pop          = 1'b0;
        trig_start   = 1'b0;
        div_start    = 1'b0;
        div_dividend = diffx[32] ? DIVD_W'(-diffx) : DIVD_W'(diffx);
        ram_we       = 1'b0;
        ram_wdata    = head.cell_wall;
        ram_addr     = (state_reg == S_IDLE) ? head.cell_addr : cast_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    if (head.cmd == CMD_WRITE)
                    begin
                        ram_we = head.cell_keep;
                    end
                    else
                    begin
                        beam_next  = head.beam;
                        negx_next  = diffx[32];
                        diffy_next = $signed({head.pos_y[31], head.pos_y})
                                   - $signed({cfg.map_origin_y[31], cfg.map_origin_y});
                        trig_start = 1'b1;
                        div_start  = 1'b1;
                        dist_next  = '0;
                        fx_next    = '0;
                        fy_next    = '0;
                        state_next = S_DIVX;
                    end
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    gx_next      = gq;
                    remx_next    = gr;
                    negy_next    = diffy_reg[32];
                    div_dividend = diffy_reg[32] ? DIVD_W'(-diffy_reg) : DIVD_W'(diffy_reg);
                    div_start    = 1'b1;
                    state_next   = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    gy_next    = gq;
                    remy_next  = gr;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                // wait for the trig unit, then take one cell step or stop
                if (!trig_busy)
                begin
                    if ({1'b0, cfg.max_range} > dist_reg)
                    begin
                        dist_next  = DIST_W'(dist_reg + step);
                        state_next = S_MUL;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        result_next = '{beam_out: beam_reg, hit: 1'b0, hit_range: '0};
                        state_next  = S_IDLE;
                    end
                end
            end
            S_MUL:
            begin
                prodx_next = $signed({1'b0, dist_reg}) * cos_val;
                prody_next = $signed({1'b0, dist_reg}) * sin_val;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                remx_next  = REM_W'(remx_reg + (fxn - fx_reg));
                remy_next  = REM_W'(remy_reg + (fyn - fy_reg));
                fx_next    = fxn;
                fy_next    = fyn;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                // move the cell until both remainders lie within one cell edge
                if (remx_reg < 0)
                begin
                    remx_next = remx_reg + step_s;
                    gx_next   = gx_reg - 1'b1;
                end
                else if (remx_reg >= step_s)
                begin
                    remx_next = remx_reg - step_s;
                    gx_next   = gx_reg + 1'b1;
                end
                if (remy_reg < 0)
                begin
                    remy_next = remy_reg + step_s;
                    gy_next   = gy_reg - 1'b1;
                end
                else if (remy_reg >= step_s)
                begin
                    remy_next = remy_reg - step_s;
                    gy_next   = gy_reg + 1'b1;
                end
                if (remx_reg >= 0 && remx_reg < step_s && remy_reg >= 0 && remy_reg < step_s)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                if (gx_reg < 0 || gx_reg >= cols_s || gy_reg < 0 || gy_reg >= rows_s)
                begin
                    done_next   = 1'b1;
                    result_next = '{beam_out: beam_reg, hit: 1'b0, hit_range: '0};
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (ram_rdata)
                begin
                    done_next   = 1'b1;
                    result_next = '{beam_out: beam_reg, hit: 1'b1, hit_range: dist_reg};
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beam_reg   <= beam_next;
        negx_reg   <= negx_next;
        negy_reg   <= negy_next;
        diffy_reg  <= diffy_next;
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        remx_reg   <= remx_next;
        remy_reg   <= remy_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        dist_reg   <= dist_next;
        prodx_reg  <= prodx_next;
        prody_reg  <= prody_next;
        result_reg <= result_next;
    end

endmodule

### src/occupancy_grid_ray_cast_core.sv
// Top level of the occupancy grid ray caster: register file and the three parts.
// Depends on ogrc_pkg, ogrc_front, ogrc_queue and ogrc_back.
//
//   channel   handshake             payload    direction
//   request   start / busy          request_t  in
//   result    done (one cycle)      result_t   out
//   config    psel penable pwrite   pwdata     in, APB, pready tied high
//
// A map write is done in the ray engine in the cycle that pops it. A cast finds its
// starting cell first: the cycle that pops it starts the divider on x, then on y;
// it then steps through S_STEP to S_CHECK per cell, holding S_NORM for extra boundaries.
// Reset is asynchronous and active low; the map contents stay undefined.
// busy is high while the two-entry request queue is full; results cannot be held off.
module occupancy_grid_ray_cast_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  ogrc_pkg::request_t              request,
    output logic                            busy,
    output logic                            done,
    output ogrc_pkg::result_t               result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ogrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import ogrc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic [2:0] reg_index;
    logic       cfg_write;
    logic       push, full, pop, head_valid;
    entry_t     entry, head;

    assign pready    = 1'b1;
    assign reg_index = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Write one register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_CELL_SIZE:   cfg_next.cell_size        = pwdata[20:0];
                REG_ORIGIN_X:    cfg_next.map_origin_x     = pwdata;
                REG_ORIGIN_Y:    cfg_next.map_origin_y     = pwdata;
                REG_MAP_COLUMNS: cfg_next.map_columns      = pwdata[9:0];
                REG_MAP_ROWS:    cfg_next.map_rows         = pwdata[9:0];
                REG_MAX_RANGE:   cfg_next.max_range        = pwdata[23:0];
                REG_FIRST_ANGLE: cfg_next.first_beam_angle = pwdata[15:0];
                REG_ANGLE_STEP:  cfg_next.beam_angle_step  = pwdata[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back one register
    always_comb
    begin
        unique case (reg_index)
            REG_CELL_SIZE:   prdata = 32'(cfg_reg.cell_size);
            REG_ORIGIN_X:    prdata = cfg_reg.map_origin_x;
            REG_ORIGIN_Y:    prdata = cfg_reg.map_origin_y;
            REG_MAP_COLUMNS: prdata = 32'(cfg_reg.map_columns);
            REG_MAP_ROWS:    prdata = 32'(cfg_reg.map_rows);
            REG_MAX_RANGE:   prdata = 32'(cfg_reg.max_range);
            REG_FIRST_ANGLE: prdata = 32'(cfg_reg.first_beam_angle);
            REG_ANGLE_STEP:  prdata = 32'(cfg_reg.beam_angle_step);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_size        <= CELL_SIZE_RST;
            cfg_reg.map_origin_x     <= '0;
            cfg_reg.map_origin_y     <= '0;
            cfg_reg.map_columns      <= MAP_SIZE_RST;
            cfg_reg.map_rows         <= MAP_SIZE_RST;
            cfg_reg.max_range        <= MAX_RANGE_RST;
            cfg_reg.first_beam_angle <= '0;
            cfg_reg.beam_angle_step  <= ANGLE_STEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ogrc_front u_front (
        .start            (start),
        .request          (request),
        .first_beam_angle (cfg_reg.first_beam_angle),
        .beam_angle_step  (cfg_reg.beam_angle_step),
        .full             (full),
        .busy             (busy),
        .push             (push),
        .entry            (entry)
    );

    ogrc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .din        (entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    ogrc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .done       (done),
        .result     (result)
    );

endmodule

### src/ogrc_checker.sv
// Port-level checks on the ray caster, bound to the top level.
// Depends on ogrc_pkg and occupancy_grid_ray_cast_core.
module ogrc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input ogrc_pkg::result_t result,
    input logic              pready
);
    import ogrc_pkg::*;

    // A miss reports zero range
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.hit || result.hit_range == '0))
        else $error("miss with non-zero range");

    // Each cast runs the divisions and the cell states, so results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results on consecutive cycles");

    // The queue fills only on an incoming request
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    // The register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind occupancy_grid_ray_cast_core ogrc_checker u_ogrc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result),
    .pready (pready)
);

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of occupancy_grid_ray_cast_core: map writes and ray casts
// are predicted in a scoreboard class and compared with every result strobe.
// Depends on ogrc_pkg and the RTL of the core.
module testbench;
    import ogrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REQ_W          = $bits(request_t);

    // Ray cast predictor and store of outstanding ranges
    class range_board;
        cfg_t     cfg;
        bit       occ[MAP_CELLS];
        bit       written[MAP_CELLS];
        result_t  ranges_due[$];
        int       failures;

        function new();
            cfg.cell_size        = CELL_SIZE_RST;
            cfg.map_origin_x     = '0;
            cfg.map_origin_y     = '0;
            cfg.map_columns      = MAP_SIZE_RST;
            cfg.map_rows         = MAP_SIZE_RST;
            cfg.max_range        = MAX_RANGE_RST;
            cfg.first_beam_angle = '0;
            cfg.beam_angle_step  = ANGLE_STEP_RST;
            failures             = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_CELL_SIZE:   cfg.cell_size        = v[20:0];
                REG_ORIGIN_X:    cfg.map_origin_x     = v;
                REG_ORIGIN_Y:    cfg.map_origin_y     = v;
                REG_MAP_COLUMNS: cfg.map_columns      = v[9:0];
                REG_MAP_ROWS:    cfg.map_rows         = v[9:0];
                REG_MAX_RANGE:   cfg.max_range        = v[23:0];
                REG_FIRST_ANGLE: cfg.first_beam_angle = v[15:0];
                default:         cfg.beam_angle_step  = v[15:0];
            endcase
        endfunction

        function longint cols_eff();
            return (cfg.map_columns > MAP_SIDE) ? MAP_SIDE : cfg.map_columns;
        endfunction

        function longint rows_eff();
            return (cfg.map_rows > MAP_SIDE) ? MAP_SIDE : cfg.map_rows;
        endfunction

        function longint step_eff();
            return (cfg.cell_size == 0) ? 1 : cfg.cell_size;
        endfunction

        // Floor division for a positive divisor
        function longint div_down(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q = q - 1;
            return q;
        endfunction

        // Fold into the right half plane, then rotate in sixteen stages
        function void rotate(logic [15:0] ang, output longint c, output longint s);
            int     atan_tab[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                     41, 20, 10, 5, 3, 1, 1, 0};
            longint x;
            longint y;
            longint nx;
            longint z;
            bit     flip;
            x = 652032874;
            y = 0;
            flip = (ang >= 16384 && ang < 49152);
            if (flip)
                z = longint'(ang) - 32768;
            else
                z = (ang < 32768) ? longint'(ang) : longint'(ang) - 65536;
            for (int i = 0; i < 16; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - atan_tab[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + atan_tab[i];
                end
                x = nx;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        // Note an accepted request and work out its range, if any
        function void note_request(request_t r);
            logic [15:0] ang;
            longint      cs;
            longint      sn;
            longint      stp;
            longint      cols;
            longint      rows;
            longint      reach;
            longint      px;
            longint      py;
            longint      gx;
            longint      gy;
            bit          hit;
            result_t     res;
            if (r.cmd == CMD_WRITE)
            begin
                occ[r.cell_index]     = (r.cell_value == WALL_VALUE);
                written[r.cell_index] = 1'b1;
                return;
            end
            ang = 16'(r.robot_heading + cfg.first_beam_angle +
                      r.beam_number * cfg.beam_angle_step);
            rotate(ang, cs, sn);
            stp   = step_eff();
            cols  = cols_eff();
            rows  = rows_eff();
            reach = 0;
            hit   = 0;
            while (reach < longint'(cfg.max_range))
            begin
                reach = reach + stp;
                px = longint'(r.robot_x) + ((reach * cs) >>> 30);
                py = longint'(r.robot_y) + ((reach * sn) >>> 30);
                gx = div_down(px - longint'(cfg.map_origin_x), stp);
                gy = div_down(py - longint'(cfg.map_origin_y), stp);
                if (gx < 0 || gy < 0 || gx >= cols || gy >= rows)
                    break;
                if (occ[gy * cols + gx])
                begin
                    hit = 1;
                    break;
                end
            end
            res.beam_out  = r.beam_number;
            res.hit       = hit;
            res.hit_range = hit ? 25'(reach) : '0;
            ranges_due.push_back(res);
        endfunction

        // Compare one strobed result with the oldest outstanding range
        function void check_result(result_t got);
            result_t want;
            if (ranges_due.size() == 0)
            begin
                $error("result with nothing outstanding: beam %0d", got.beam_out);
                failures++;
                return;
            end
            want = ranges_due.pop_front();
            if (got.beam_out !== want.beam_out)
            begin
                $error("beam_out: expected %0d, got %0d", want.beam_out, got.beam_out);
                failures++;
            end
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                failures++;
            end
            if (got.hit_range !== want.hit_range)
            begin
                $error("hit_range: expected %0d, got %0d", want.hit_range, got.hit_range);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    request_t    request = '0;
    logic        busy;
    logic        done;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    range_board  board = new();
    int          burst_left = 0;
    int          quiet_cycles = 0;

    occupancy_grid_ray_cast_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Check results and watch for a stalled run
    always @(posedge clk)
    begin
        if (done)
            board.check_result(result);
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive one request, holding start across a burst
    task automatic send(request_t r);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        board.note_request(r);
        burst_left--;
    endtask

    // Drop start and wait until every range is in and the engine is quiet
    task automatic settle();
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.ranges_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, v);
    endtask

    task automatic write_cell(logic [17:0] idx, logic [7:0] v);
        request_t r;
        r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
        r.cmd        = CMD_WRITE;
        r.cell_index = idx;
        r.cell_value = v;
        send(r);
    endtask

    function automatic logic [7:0] cell_byte();
        return ($urandom_range(0, 5) == 0) ? 8'(WALL_VALUE) : 8'($urandom);
    endfunction

    // Write every cell of the map in use that has not been written yet
    task automatic fill_map();
        longint cells;
        cells = board.cols_eff() * board.rows_eff();
        for (longint i = 0; i < cells; i++)
            if (!board.written[i])
                write_cell(18'(i), cell_byte());
    endtask

    task automatic configure(logic [31:0] cs, logic [31:0] ox, logic [31:0] oy,
                             logic [31:0] cols, logic [31:0] rows, logic [31:0] rng,
                             logic [31:0] first, logic [31:0] step);
        settle();
        reg_write(REG_CELL_SIZE, cs);
        reg_write(REG_ORIGIN_X, ox);
        reg_write(REG_ORIGIN_Y, oy);
        reg_write(REG_MAP_COLUMNS, cols);
        reg_write(REG_MAP_ROWS, rows);
        reg_write(REG_MAX_RANGE, rng);
        reg_write(REG_FIRST_ANGLE, first);
        reg_write(REG_ANGLE_STEP, step);
        fill_map();
    endtask

    task automatic cast(logic [31:0] x, logic [31:0] y, logic [15:0] head,
                        logic [11:0] beam);
        request_t r;
        r = REQ_W'({$urandom, $urandom, $urandom, $urandom});
        r.cmd           = CMD_CAST;
        r.robot_x       = x;
        r.robot_y       = y;
        r.robot_heading = head;
        r.beam_number   = beam;
        send(r);
    endtask

    // Mostly a point on the map, sometimes anywhere
    function automatic logic [31:0] pick_coord(longint origin, longint cells);
        longint span;
        span = cells * board.step_eff();
        if ($urandom_range(0, 9) < 8)
            return 32'(origin + longint'($urandom_range(0, 32'(span))));
        return $urandom;
    endfunction

    // Random casts with some map rewrites and stray writes mixed in
    task automatic random_casts(int n);
        longint cells;
        cells = board.cols_eff() * board.rows_eff();
        for (int i = 0; i < n; i++)
        begin
            if (cells > 0 && $urandom_range(0, 9) < 2)
                write_cell(18'($urandom_range(0, 32'(cells - 1))), cell_byte());
            else if ($urandom_range(0, 19) == 0)
                write_cell(18'($urandom), cell_byte());
            cast(pick_coord(board.cfg.map_origin_x, board.cols_eff()),
                 pick_coord(board.cfg.map_origin_y, board.rows_eff()),
                 16'($urandom), 12'($urandom));
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Writes at the end of the store and at the ends of the value range
        write_cell(18'h3FFFF, 8'h80);
        write_cell(18'h3FFFF, 8'h7F);
        write_cell(18'h3FFFE, 8'(WALL_VALUE));

        // One-metre cells, 16 by 16, directed poses and headings
        configure(32'd65536, 32'd0, 32'd0, 32'd16, 32'd16, 32'd1310720, 32'd0, 32'd46);
        cast(32'h0008_0000, 32'h0008_0000, 16'd0, 12'd0);
        cast(32'h0008_0000, 32'h0008_0000, 16'd16384, 12'd4095);
        cast(32'h0008_0000, 32'h0008_0000, 16'd32768, 12'd1);
        cast(32'h0008_0000, 32'h0008_0000, 16'd49152, 12'd2048);
        cast(32'h0008_0000, 32'h0008_0000, 16'd65535, 12'd0);
        cast(32'h0000_8000, 32'h0000_8000, 16'd8192, 12'd0);
        cast(32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 12'd0);
        cast(32'hFFFF_FFFF, 32'h0000_0000, 16'd24576, 12'd100);
        random_casts(15);

        // Zero cell size taken as one unit
        configure(32'hFFE0_0000, 32'd0, 32'd0, 32'd16, 32'd16, 32'd40, 32'd300, 32'd9);
        random_casts(15);

        // Large cells, origin below zero, widest angles
        configure(32'd1048576, 32'hFF9C_0000, 32'h8000_0000, 32'd20, 32'd12,
                  32'h00FF_FFFF, 32'd65535, 32'd65535);
        random_casts(15);

        // Full width and full height, plain and saturated
        configure(32'd3277, 32'd0, 32'd0, 32'd512, 32'd1, 32'h00FF_FFFF, 32'd0, 32'd46);
        random_casts(12);
        configure(32'd3277, 32'd0, 32'd0, 32'd1023, 32'd1, 32'h00FF_FFFF, 32'd16384, 32'd1);
        random_casts(8);
        configure(32'd3277, 32'd0, 32'd0, 32'd1, 32'd1023, 32'h00FF_FFFF, 32'd16384, 32'd1);
        random_casts(12);

        // Empty map, then zero range limit
        configure(32'd65536, 32'd0, 32'd0, 32'd0, 32'd5, 32'd655360, 32'd0, 32'd46);
        random_casts(6);
        configure(32'd65536, 32'd0, 32'd0, 32'd8, 32'd8, 32'd0, 32'd0, 32'd46);
        random_casts(6);

        // Random small maps
        for (int p = 0; p < 8; p++)
        begin
            configure($urandom_range(2000, 200000), $urandom, $urandom,
                      $urandom_range(1, 24), $urandom_range(1, 24),
                      $urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
            random_casts(12);
        end

        settle();
        if (board.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
